FILE: sv/pisd_pkg.sv
// Shared types, constants and helper functions of the packed index symbol decoder.
package pisd_pkg;

    localparam int TABLE_DEPTH   = 4096;
    localparam int TABLE_ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CODE_BITS_MAX = 12;
    localparam int CODE_W        = 12;
    localparam int ENTRY_W       = 32;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 3;
    localparam int BUF_W         = 24;
    localparam int BCNT_W        = 5;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FMT   = 1'b1;

    // Output formats.
    localparam logic [2:0] FMT_SINGLE   = 3'd0;
    localparam logic [2:0] FMT_UTF8     = 3'd1;
    localparam logic [2:0] FMT_UTF16_BE = 3'd2;
    localparam logic [2:0] FMT_UTF16_LE = 3'd3;
    localparam logic [2:0] FMT_QUAD     = 3'd4;

    localparam logic [15:0] SURR_LOW  = 16'hD800;
    localparam logic [15:0] SURR_HIGH = 16'hDFFF;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [CODE_W-1:0]    index;
        logic [ENTRY_W-1:0]   word;
    } t_cmd;

    typedef struct packed {
        logic       clear;
        logic [3:0] code_bits;
        logic [2:0] out_fmt;
    } t_cfg;

    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_EXTRACT = 1'b1
    } t_bstate;

    // Clamp the programmed width into 1..CODE_BITS_MAX.
    function automatic logic [3:0] eff_width(input logic [3:0] code_bits);
        logic [3:0] w;
        w = code_bits;
        if (w == 4'd0) begin
            w = 4'd1;
        end else if (w > 4'(CODE_BITS_MAX)) begin
            w = 4'(CODE_BITS_MAX);
        end
        return w;
    endfunction

    function automatic logic [COUNT_W-1:0] utf8_len(input logic [7:0] lead);
        logic [COUNT_W-1:0] n;
        if (lead[7] == 1'b0) begin
            n = 3'd1;
        end else if (lead[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (lead[7:3] == 5'b11110) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic [COUNT_W-1:0] byte_count_for(
        input logic [2:0]         fmt,
        input logic [ENTRY_W-1:0] entry
    );
        logic [15:0]        word;
        logic [COUNT_W-1:0] n;
        word = (fmt == FMT_UTF16_BE) ? {entry[7:0], entry[15:8]} : entry[15:0];
        unique case (fmt)
            FMT_SINGLE: n = 3'd1;
            FMT_UTF8:   n = utf8_len(entry[7:0]);
            FMT_UTF16_BE, FMT_UTF16_LE: begin
                n = (word >= SURR_LOW && word <= SURR_HIGH) ? 3'd4 : 3'd2;
            end
            FMT_QUAD:   n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: sv/pisd_in_if.sv
// Request channel of the decoder: table loads and packed data bytes.
interface pisd_in_if;
    import pisd_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [CODE_W-1:0]   entry_index;
    logic [ENTRY_W-1:0]  entry_word;
    logic [BYTE_W-1:0]   data_byte;

    modport source (output valid, mode, entry_index, entry_word, data_byte, input ready);
    modport sink   (input valid, mode, entry_index, entry_word, data_byte, output ready);
endinterface

FILE: sv/pisd_out_if.sv
// Result channel of the decoder: decoded symbols, one per table lookup.
interface pisd_out_if;
    import pisd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ENTRY_W-1:0]  symbol_bytes;
    logic [COUNT_W-1:0]  byte_count;
    logic [CODE_W-1:0]   code_value;
    logic                last_of_run;

    modport source (output valid, symbol_bytes, byte_count, code_value, last_of_run,
                    input ready);
    modport sink   (input valid, symbol_bytes, byte_count, code_value, last_of_run,
                    output ready);
endinterface

FILE: sv/pisd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pisd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pisd_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module pisd_front import pisd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pisd_in_if.sink     i_in,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    // A data byte rides in the low bits of the word field.
    always_comb begin
        if (i_in.mode) begin
            w_cmd.kind  = KIND_DATA;
            w_cmd.index = '0;
            w_cmd.word  = {{(ENTRY_W-BYTE_W){1'b0}}, i_in.data_byte};
        end else begin
            w_cmd.kind  = KIND_LOAD;
            w_cmd.index = i_in.entry_index;
            w_cmd.word  = i_in.entry_word;
        end
    end

    assign i_in.ready  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = i_cmd_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: sv/pisd_back.sv
// Back end: table writes, bit buffer unpacking, table lookups and the result register.
module pisd_back import pisd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    pisd_out_if.source  o_out
);

    t_bstate              r_state, n_state;
    logic [BUF_W-1:0]     r_buf, n_buf;
    logic [BCNT_W-1:0]    r_bcnt, n_bcnt;
    logic                 r_pend, n_pend;
    logic [CODE_W-1:0]    r_pend_idx, n_pend_idx;
    logic                 r_pend_last, n_pend_last;
    logic                 r_ov;
    logic [ENTRY_W-1:0]   r_osym;
    logic [COUNT_W-1:0]   r_ocnt;
    logic [CODE_W-1:0]    r_oidx;
    logic                 r_olast;

    logic [3:0]              w_width;
    logic [BCNT_W-1:0]       w_width_x;
    logic [CODE_W-1:0]       w_mask;
    logic [CODE_W-1:0]       w_idx;
    logic                    w_can_load;
    logic                    w_issue;
    logic                    w_ram_we;
    logic [ENTRY_W-1:0]      w_rdata;

    assign w_width    = eff_width(i_cfg.code_bits);
    assign w_width_x  = {{(BCNT_W-4){1'b0}}, w_width};
    assign w_mask     = CODE_W'(({{CODE_W{1'b0}}, 1'b1} << w_width) - 1'b1);
    assign w_idx      = r_buf[CODE_W-1:0] & w_mask;
    assign w_can_load = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_buf   <= '0;
            r_bcnt  <= '0;
            r_pend  <= 1'b0;
        end else if (i_cfg.clear) begin
            r_state <= n_state;
            r_buf   <= '0;
            r_bcnt  <= '0;
            r_pend  <= n_pend;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_bcnt  <= n_bcnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_pend_last <= n_pend_last;
    end

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_bcnt      = r_bcnt;
        n_pend_idx  = r_pend_idx;
        n_pend_last = r_pend_last;
        o_cmd_pop   = 1'b0;
        w_ram_we    = 1'b0;
        w_issue     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == KIND_LOAD) begin
                        w_ram_we = 1'b1;
                    end else begin
                        n_buf   = r_buf | (BUF_W'(i_cmd.word[BYTE_W-1:0]) << r_bcnt);
                        n_bcnt  = r_bcnt + BCNT_W'(BYTE_W);
                        n_state = ST_EXTRACT;
                    end
                end
            end
            ST_EXTRACT: begin
                if (r_bcnt < w_width_x) begin
                    n_state = ST_IDLE;
                end else if (!r_pend || w_can_load) begin
                    w_issue     = 1'b1;
                    n_buf       = r_buf >> w_width;
                    n_bcnt      = r_bcnt - w_width_x;
                    n_pend_idx  = w_idx;
                    n_pend_last = (n_bcnt < w_width_x);
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_issue) begin
            n_pend = 1'b1;
        end else if (r_pend && w_can_load) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    pisd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_cmd.index[TABLE_ADDR_W-1:0]),
        .i_wdata (i_cmd.word),
        .i_re    (w_issue),
        .i_raddr (w_idx[TABLE_ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_pend && w_can_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_can_load) begin
            r_osym  <= w_rdata;
            r_ocnt  <= byte_count_for(i_cfg.out_fmt, w_rdata);
            r_oidx  <= r_pend_idx;
            r_olast <= r_pend_last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.symbol_bytes = r_osym;
    assign o_out.byte_count   = r_ocnt;
    assign o_out.code_value   = r_oidx;
    assign o_out.last_of_run  = r_olast;

    // The buffer never holds more than one partial index plus one byte.
    a_bcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BCNT_W'(CODE_BITS_MAX - 1 + BYTE_W))
        else $error("bit count exceeds buffer bound");

    // Table reads start only while unpacking a data byte.
    a_issue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_state == ST_EXTRACT && r_bcnt >= w_width_x))
        else $error("table read outside unpacking");

    // A lookup waiting on a full result register must keep its read data.
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_can_load) |=> (r_pend && $stable(w_rdata)))
        else $error("pending lookup data lost");

    // Back in idle, no complete index is left in the buffer.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_bcnt < w_width_x))
        else $error("idle with a full index still buffered");

endmodule

FILE: sv/packed_index_symbol_decoder.sv
// Top level of the packed index symbol decoder: configuration registers, front and back end.
//
//   channel   direction  handshake           payload
//   i_in      in         valid / ready       mode, entry_index, entry_word, data_byte
//   o_out     out        valid / ready       symbol_bytes, byte_count, code_value, last_of_run
//   cfg       in         i_cfg_we (no wait)  i_cfg_index, i_cfg_data
//
// A table load request is written into the symbol table from the idle state. A data byte
// is first shifted into the bit buffer; the back end then looks up one symbol per cycle
// while the result register can take it, until no whole index is left, and only then
// goes back to idle for the next request; the table's single read port sets this rate.
// Reset is synchronous and active low; it clears the bit buffer, the queue and the result
// valid flag but not the symbol table, which holds garbage until each slot is loaded.
// A two-entry request queue separates the input from the back end, and the result
// register takes a new symbol in the same cycle the previous one is taken, so either
// side may stall without losing or repeating a symbol.
module packed_index_symbol_decoder import pisd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pisd_in_if.sink               i_in,
    pisd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0] r_code_bits;
    logic [2:0] r_out_fmt;
    t_cfg       w_cfg;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_cmd_pop;

    // The user must write configuration only while the block is idle; it is not enforced. Writing the code width
    // also empties the bit buffer so that the next stream starts on a clean boundary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= 4'd1;
            r_out_fmt   <= FMT_SINGLE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_CODE_BITS) begin
                r_code_bits <= i_cfg_data[3:0];
            end else if (i_cfg_index == REG_OUT_FMT) begin
                r_out_fmt <= i_cfg_data[2:0];
            end
        end
    end

    assign w_cfg.clear     = i_cfg_we && (i_cfg_index == REG_CODE_BITS);
    assign w_cfg.code_bits = r_code_bits;
    assign w_cfg.out_fmt   = r_out_fmt;

    // The front end keeps requests in arrival order, so a table load never overtakes
    // the lookups of an earlier data byte.
    pisd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // The back end owns the symbol table, the bit buffer and the result register.
    pisd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_out       (o_out)
    );

endmodule

FILE: verif/packed_index_symbol_decoder_tb.sv
// Self-checking testbench of the packed index symbol decoder: table loads, packed data, checks.
module packed_index_symbol_decoder_tb import pisd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Format codes that the block does not define; they must give a byte count of zero.
    localparam logic [2:0] FMT_RSVD5 = 3'd5;
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    // Widths up to this one get every table slot loaded, so any data byte is legal.
    localparam int FULL_TABLE_W = 4;
    // Cycles allowed after the last expected symbol for a request that yields none.
    localparam int DRAIN_CYCLES = 20;
    // Cycles in a row without any accepted request or symbol before the run is abandoned.
    localparam int QUIET_LIMIT  = 1000;
    localparam int NUM_PHASES   = 12;

    // One request as the sender presents it.
    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   index;
        logic [ENTRY_W-1:0]  word;
        logic [BYTE_W-1:0]   dbyte;
    } t_req;

    // One decoded symbol as the block should deliver it.
    typedef struct {
        logic [ENTRY_W-1:0] symbol_bytes;
        logic [COUNT_W-1:0] byte_count;
        logic [CODE_W-1:0]  code_value;
        logic               last_of_run;
    } t_symbol;

    // Mirrors the decoder: its own table, bit buffer and registers, and the symbols that the
    // accepted requests still owe.
    class symbol_scoreboard;
        logic [ENTRY_W-1:0] sym_table [TABLE_DEPTH];
        logic [BUF_W-1:0]   bits_held;
        int                 bits_valid;
        logic [3:0]         width_reg;
        logic [2:0]         fmt_reg;
        t_symbol            expected_q [$];
        int                 errors;

        function new();
            width_reg  = 4'd1;
            fmt_reg    = FMT_SINGLE;
            bits_held  = '0;
            bits_valid = 0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // A width write also throws away whatever bits are left in the buffer.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_CODE_BITS) begin
                width_reg  = val;
                bits_held  = '0;
                bits_valid = 0;
            end else begin
                fmt_reg = val[2:0];
            end
        endfunction

        function logic [COUNT_W-1:0] count_bytes(logic [ENTRY_W-1:0] entry);
            logic [15:0] unit16;
            case (fmt_reg)
                FMT_SINGLE: return 3'd1;
                FMT_QUAD:   return 3'd4;
                FMT_UTF8: begin
                    casez (entry[7:0])
                        8'b0???????: return 3'd1;
                        8'b110?????: return 3'd2;
                        8'b1110????: return 3'd3;
                        8'b11110???: return 3'd4;
                        default:     return 3'd0;
                    endcase
                end
                FMT_UTF16_BE, FMT_UTF16_LE: begin
                    if (fmt_reg == FMT_UTF16_BE) begin
                        unit16 = {entry[7:0], entry[15:8]};
                    end else begin
                        unit16 = entry[15:0];
                    end
                    return (unit16 >= SURR_LOW && unit16 <= SURR_HIGH) ? 3'd4 : 3'd2;
                end
                default: return 3'd0;
            endcase
        endfunction

        function void note_request(t_kind kind, logic [CODE_W-1:0] index,
                                   logic [ENTRY_W-1:0] word, logic [BYTE_W-1:0] dbyte);
            int      w;
            int      total;
            t_symbol s;
            if (kind == KIND_LOAD) begin
                sym_table[index] = word;
                return;
            end
            w = (width_reg == 4'd0) ? 1 :
                ((width_reg > CODE_BITS_MAX) ? CODE_BITS_MAX : int'(width_reg));
            bits_held  = bits_held | (BUF_W'(dbyte) << bits_valid);
            bits_valid = bits_valid + 8;
            total      = bits_valid / w;
            for (int n = 0; n < total; n++) begin
                s.code_value   = CODE_W'(bits_held & ((BUF_W'(1) << w) - BUF_W'(1)));
                s.symbol_bytes = sym_table[s.code_value];
                s.byte_count   = count_bytes(s.symbol_bytes);
                s.last_of_run  = (n == total - 1);
                bits_held      = bits_held >> w;
                bits_valid     = bits_valid - w;
                expected_q.push_back(s);
            end
        endfunction

        function void check_symbol(logic [ENTRY_W-1:0] symbol_bytes,
                                   logic [COUNT_W-1:0] byte_count,
                                   logic [CODE_W-1:0] code_value, logic last_of_run);
            t_symbol s;
            if (expected_q.size() == 0) begin
                $error("symbol with code_value %0h arrived with nothing expected", code_value);
                errors++;
                return;
            end
            s = expected_q.pop_front();
            if (symbol_bytes !== s.symbol_bytes) begin
                $error("symbol_bytes: expected %08h, got %08h", s.symbol_bytes, symbol_bytes);
                errors++;
            end
            if (byte_count !== s.byte_count) begin
                $error("byte_count: expected %0d, got %0d", s.byte_count, byte_count);
                errors++;
            end
            if (code_value !== s.code_value) begin
                $error("code_value: expected %03h, got %03h", s.code_value, code_value);
                errors++;
            end
            if (last_of_run !== s.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b", s.last_of_run, last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  rx_ready = 1'b0;

    pisd_in_if  in_ch ();
    pisd_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    packed_index_symbol_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    symbol_scoreboard sb = new();

    // Requests of the current phase, waiting to be driven.
    t_req stim_q [$];

    // Which table slots hold a known entry; data is only ever built to read these.
    bit slot_loaded [TABLE_DEPTH];
    int loaded_list [$];

    // Codes still waiting to fill a whole byte of the packed stream.
    logic [31:0] pack_acc = '0;
    int          pack_bits = 0;

    // Receiver behavior: 0 always ready, 1 short random stalls, 2 long stalls.
    int rx_style = 1;
    int stall_left = 0;

    // The code widths and formats that the random phases walk through. Width 0 and the
    // values above the maximum are in the list on purpose, as are all three unused formats.
    logic [3:0] phase_width [NUM_PHASES] = '{
        4'd1, 4'd12, 4'd2, 4'd4, 4'd0, 4'd15, 4'd6, 4'd9, 4'd3, 4'd11, 4'd13, 4'd7
    };
    logic [2:0] phase_fmt [NUM_PHASES] = '{
        FMT_UTF16_BE, FMT_UTF16_LE, FMT_QUAD, FMT_UTF8, FMT_RSVD5, FMT_SINGLE,
        FMT_UTF8, FMT_UTF16_LE, FMT_RSVD6, FMT_UTF16_BE, FMT_RSVD7, FMT_UTF8
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Table entries are biased toward the lead bytes that decide the UTF-8 length and
    // toward UTF-16 code units on and around the surrogate range, in either byte order.
    function automatic logic [ENTRY_W-1:0] make_symbol_word();
        logic [ENTRY_W-1:0] wd;
        wd = $urandom;
        case ($urandom_range(0, 9))
            1: wd[7] = 1'b0;
            2: wd[7:5] = 3'b110;
            3: wd[7:4] = 4'b1110;
            4: wd[7:3] = 5'b11110;
            5: wd[7:6] = 2'b10;
            6: wd[7:3] = 5'b11111;
            7: wd[7:3] = 5'b11011;
            8: wd[15:11] = 5'b11011;
            9: begin
                case ($urandom_range(0, 3))
                    0: wd[15:0] = 16'hD7FF;
                    1: wd[15:0] = 16'hD800;
                    2: wd[15:0] = 16'hDFFF;
                    default: wd[15:0] = 16'hE000;
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    wd[15:0] = {wd[7:0], wd[15:8]};
                end
            end
            default: ;
        endcase
        return wd;
    endfunction

    function automatic void add_load(input logic [CODE_W-1:0] idx,
                                     input logic [ENTRY_W-1:0] word);
        t_req r;
        r.kind  = KIND_LOAD;
        r.index = idx;
        r.word  = word;
        r.dbyte = BYTE_W'($urandom);
        stim_q.push_back(r);
        if (!slot_loaded[idx]) begin
            slot_loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
    endfunction

    // The slot and word fields are don't-care on a data byte, so they carry noise.
    function automatic void add_byte(input logic [BYTE_W-1:0] dbyte);
        t_req r;
        r.kind  = KIND_DATA;
        r.index = CODE_W'($urandom);
        r.word  = $urandom;
        r.dbyte = dbyte;
        stim_q.push_back(r);
    endfunction

    // Appends one code, LSB first, to the packed stream and emits every byte it completes.
    function automatic void add_code(input logic [CODE_W-1:0] code, input int w);
        pack_acc  = pack_acc | (32'(code) << pack_bits);
        pack_bits = pack_bits + w;
        while (pack_bits >= 8) begin
            add_byte(pack_acc[7:0]);
            pack_acc  = pack_acc >> 8;
            pack_bits = pack_bits - 8;
        end
    endfunction

    // Closes the stream with a zero-padded byte. If the padding is at least one code wide,
    // it decodes as slot 0, which is always loaded; a shorter remainder stays in the buffer
    // until the next width write clears it.
    function automatic void flush_codes();
        if (pack_bits > 0) begin
            add_byte(pack_acc[7:0]);
        end
        pack_acc  = '0;
        pack_bits = 0;
    endfunction

    function automatic logic [CODE_W-1:0] pick_slot(input int lim);
        int cand [$];
        foreach (loaded_list[i]) begin
            if (loaded_list[i] < lim) begin
                cand.push_back(loaded_list[i]);
            end
        end
        return CODE_W'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // Configuration writes happen only while the block is idle. The mirror is updated at
    // the same time, since no request is in flight to see the difference.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drives the queued requests in bursts of random length. With gappy set, idle gaps of
    // random length fall between the bursts. Once pause_at requests have gone, the sender
    // holds off until every symbol owed so far has been delivered.
    task automatic drive_requests(input bit gappy, input int pause_at);
        t_req r;
        int   burst;
        int   gap;
        int   sent;
        sent = 0;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 12);
            gap   = gappy ? $urandom_range(0, 6) : 0;
            if (pause_at >= 0 && sent >= pause_at) begin
                pause_at = -1;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() > 0) @(posedge i_clk);
            end else if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            repeat (burst) begin
                if (stim_q.size() > 0) begin
                    r = stim_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.mode        <= r.kind;
                    in_ch.entry_index <= r.index;
                    in_ch.entry_word  <= r.word;
                    in_ch.data_byte   <= r.dbyte;
                    do @(posedge i_clk); while (!in_ch.ready);
                    sent++;
                end
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // Waits for every owed symbol, then gives a request that yields no symbol time to
    // leave the block before anything else touches its registers.
    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: stalls on its own pattern, chosen per phase by rx_style.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            rx_ready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (rx_style)
                0: rx_ready <= 1'b1;
                1: begin
                    if ($urandom_range(0, 3) == 0) begin
                        rx_ready   <= 1'b0;
                        stall_left <= $urandom_range(0, 2);
                    end else begin
                        rx_ready <= 1'b1;
                    end
                end
                default: begin
                    if ($urandom_range(0, 9) == 0) begin
                        rx_ready   <= 1'b0;
                        stall_left <= $urandom_range(3, 12);
                    end else begin
                        rx_ready <= 1'($urandom_range(0, 1));
                    end
                end
            endcase
        end
    end

    // Monitor: every accepted request feeds the mirror, every accepted symbol is checked
    // against the oldest one owed. It also counts cycles in which nothing moves at all.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_request(t_kind'(in_ch.mode), in_ch.entry_index, in_ch.entry_word,
                                in_ch.data_byte);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_symbol(out_ch.symbol_bytes, out_ch.byte_count, out_ch.code_value,
                                out_ch.last_of_run);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("nothing accepted for %0d cycles, %0d symbols still owed",
                       QUIET_LIMIT, sb.pending());
                $display("packed_index_symbol_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : main
        int w;
        int lim;
        int n;

        in_ch.valid       <= 1'b0;
        in_ch.mode        <= KIND_LOAD;
        in_ch.entry_index <= '0;
        in_ch.entry_word  <= '0;
        in_ch.data_byte   <= '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First the values that reset leaves: one-bit codes, single bytes.
        // Slots 0 and 1 carry the extreme words, and the data bytes take both extremes.
        add_load(12'h000, 32'h0000_0000);
        add_load(12'h001, 32'hFFFF_FFFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        drive_requests(1'b1, -1);
        wait_idle();

        // Width 0 must behave as width 1; an unused format must give a zero count.
        write_reg(REG_CODE_BITS, 4'd0);
        write_reg(REG_OUT_FMT, CFG_DATA_W'(FMT_RSVD7));
        add_load(12'hFFF, 32'hFFFF_FFFF);
        add_byte(8'h96);
        drive_requests(1'b0, -1);
        wait_idle();

        // Width 15 must behave as the maximum width. UTF-8 lead bytes for lengths two to four and
        // two invalid ones. The first byte alone holds no whole code, and the stream ends
        // with four bits left over that the next width write has to discard.
        write_reg(REG_CODE_BITS, 4'd15);
        write_reg(REG_OUT_FMT, CFG_DATA_W'(FMT_UTF8));
        add_load(12'h0A5, 32'h0000_A2C3);
        add_load(12'h5A0, 32'h00AC_82E2);
        add_load(12'h7FF, 32'h9F98_90F0);
        add_load(12'h800, 32'h0000_0080);
        add_code(12'hFFF, 12);
        add_code(12'h0A5, 12);
        add_code(12'h5A0, 12);
        add_code(12'h7FF, 12);
        add_code(12'h800, 12);
        flush_codes();
        drive_requests(1'b1, -1);
        wait_idle();

        // Three-bit codes: one code, then zero padding that is wide enough to decode as
        // slot 0 on its own.
        write_reg(REG_CODE_BITS, 4'd3);
        write_reg(REG_OUT_FMT, CFG_DATA_W'(FMT_QUAD));
        add_load(12'h007, make_symbol_word());
        add_code(12'h007, 3);
        flush_codes();
        drive_requests(1'b1, -1);
        wait_idle();

        // Random part. Narrow widths get a fully loaded table and raw random bytes, which
        // also break any code alignment. Wider widths load a few slots, the top one among
        // them, and send well-formed packed streams of loaded indices, with table reloads
        // slipped in mid-stream.
        for (int p = 0; p < NUM_PHASES; p++) begin
            w = (phase_width[p] == 4'd0) ? 1 :
                ((phase_width[p] > CODE_BITS_MAX) ? CODE_BITS_MAX : int'(phase_width[p]));
            lim = 1 << w;
            rx_style = p % 3;
            write_reg(REG_CODE_BITS, phase_width[p]);
            write_reg(REG_OUT_FMT, CFG_DATA_W'(phase_fmt[p]));
            if (w <= FULL_TABLE_W) begin
                for (int s = 0; s < lim; s++) begin
                    if (!slot_loaded[s]) begin
                        add_load(CODE_W'(s), make_symbol_word());
                    end
                end
                repeat (2) add_load(CODE_W'($urandom_range(0, lim - 1)), make_symbol_word());
                repeat (8) begin
                    if ($urandom_range(0, 5) == 0) begin
                        add_load(CODE_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                 make_symbol_word());
                    end else begin
                        add_byte(BYTE_W'($urandom));
                    end
                end
            end else begin
                add_load(CODE_W'(lim - 1), make_symbol_word());
                repeat (4) add_load(CODE_W'($urandom_range(1, lim - 2)), make_symbol_word());
                n = 48 / w;
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0) begin
                        add_load(pick_slot(lim), make_symbol_word());
                    end
                    add_code(pick_slot(lim), w);
                end
                flush_codes();
            end
            // One phase holds the sender back mid-stream until the block has drained.
            drive_requests(p % 4 != 1, (p == 3) ? 6 : -1);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("packed_index_symbol_decoder_tb: PASS");
        end else begin
            $display("packed_index_symbol_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: packed_index_symbol_decoder.f
sv/pisd_pkg.sv
sv/pisd_in_if.sv
sv/pisd_out_if.sv
sv/pisd_ram.sv
sv/pisd_front.sv
sv/pisd_back.sv
sv/packed_index_symbol_decoder.sv
verif/packed_index_symbol_decoder_tb.sv
